FILE: rtl/core/prc_pkg.sv
// shared types and constants of the polar / rectangular converter
// no dependencies; used by every module of the converter

package prc_pkg;

	// conversion codes carried on the action field
	localparam logic ACT_TO_POLAR = 1'b0;
	localparam logic ACT_TO_RECT  = 1'b1;

	// angles as 16-bit fractions of a full turn
	localparam logic [15:0] ANG_ZERO    = 16'h0000;
	localparam logic [15:0] ANG_QUARTER = 16'h4000;
	localparam logic [15:0] ANG_HALF    = 16'h8000;
	localparam logic [15:0] ANG_THREE_Q = 16'hC000;

	// rounding offset from the 32-bit turn accumulator down to 16 bits
	localparam logic [31:0] ANG_ROUND = 32'h0000_8000;

	// 1/K as a 32-bit fraction
	localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;

	localparam logic [15:0] MAG_MAX  = 16'd46341;
	localparam logic [15:0] SAT_POS  = 16'h7FFF;
	localparam logic [15:0] SAT_NEG  = 16'h8000;

	// integer and growth bits above the datapath fraction
	localparam int GUARD_BITS = 4;

	// atan(2^-i) in 2^32 units per turn
	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// per-transaction data that rides along the cell chain unchanged
	typedef struct packed {
		logic        action;
		logic        bypass;
		logic        half;
		logic [15:0] byp_real;
		logic [15:0] byp_imag;
		logic [15:0] byp_mag;
		logic [15:0] byp_ang;
	} side_t;

	typedef struct packed {
		logic  valid;
		side_t side;
	} ctl_t;

endpackage

FILE: rtl/core/polar_rectangular_converter_unit.sv
// top level of the cordic polar / rectangular converter
// depends on prc_pkg, prc_pre, prc_cell and prc_post

// One transaction is accepted every cycle while in_stall is low, and it passes in order
// through one input stage, a chain of one cell per cordic micro-rotation, and two output
// stages for the gain multiply and the final rounding and saturation. A stall on the
// output only backs up through stages that are occupied, so empty stages keep filling
// while a finished result waits. Action 0 gives magnitude and angle (real and imaginary
// out are zero), action 1 gives saturated real and imaginary parts (magnitude and angle
// out are zero); axis inputs and axis angles take an exact shortcut around the cordic math.

module polar_rectangular_converter_unit #(
	parameter int ITERATIONS = 16,
	parameter int DATA_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [15:0] real_in,
	input  logic signed [15:0] imag_in,
	input  logic        [15:0] magnitude_in,
	input  logic        [15:0] angle_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] real_out,
	output logic signed [15:0] imag_out,
	output logic        [15:0] magnitude_out,
	output logic        [15:0] angle_out
);

	localparam int W = DATA_WIDTH + prc_pkg::GUARD_BITS;
	localparam int NUM_CELLS = (ITERATIONS < prc_pkg::ATAN_ENTRIES) ? ITERATIONS
		: prc_pkg::ATAN_ENTRIES;

	prc_pkg::ctl_t       ctl  [NUM_CELLS+1];
	logic signed [W-1:0] xv   [NUM_CELLS+1];
	logic signed [W-1:0] yv   [NUM_CELLS+1];
	logic signed [31:0]  zv   [NUM_CELLS+1];
	logic                hold [NUM_CELLS+2];

	prc_pre #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_pre (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (hold[0]),
		.action       (action),
		.real_in      (real_in),
		.imag_in      (imag_in),
		.magnitude_in (magnitude_in),
		.angle_in     (angle_in),
		.next_hold    (hold[1]),
		.ctl_out      (ctl[0]),
		.x_out        (xv[0]),
		.y_out        (yv[0]),
		.z_out        (zv[0])
	);

	assign in_stall = hold[0];

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		prc_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl[i]),
			.x_in      (xv[i]),
			.y_in      (yv[i]),
			.z_in      (zv[i]),
			.next_hold (hold[i+2]),
			.hold      (hold[i+1]),
			.ctl_out   (ctl[i+1]),
			.x_out     (xv[i+1]),
			.y_out     (yv[i+1]),
			.z_out     (zv[i+1])
		);
	end

	prc_post #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_in        (ctl[NUM_CELLS]),
		.x_in          (xv[NUM_CELLS]),
		.y_in          (yv[NUM_CELLS]),
		.z_in          (zv[NUM_CELLS]),
		.hold          (hold[NUM_CELLS+1]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.real_out      (real_out),
		.imag_out      (imag_out),
		.magnitude_out (magnitude_out),
		.angle_out     (angle_out)
	);

endmodule

FILE: rtl/core/prc_pre.sv
// input stage: axis and zero shortcuts, half-plane fold, scaling to the datapath
// depends on prc_pkg

module prc_pre #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_valid,
	output logic                                                  in_stall,
	input  logic                                                  action,
	input  logic signed [15:0]                                    real_in,
	input  logic signed [15:0]                                    imag_in,
	input  logic        [15:0]                                    magnitude_in,
	input  logic        [15:0]                                    angle_in,
	input  logic                                                  next_hold,
	output prc_pkg::ctl_t                                         ctl_out,
	output logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0]      x_out,
	output logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0]      y_out,
	output logic signed [31:0]                                    z_out
);

	localparam int W   = DATA_WIDTH + prc_pkg::GUARD_BITS;
	localparam int LSH = (DATA_WIDTH >= 15) ? DATA_WIDTH - 15 : 0;
	localparam int RSH = (DATA_WIDTH >= 15) ? 0 : 15 - DATA_WIDTH;

	logic                valid_s1;
	prc_pkg::side_t      side_s1;
	logic signed [W-1:0] x_s1;
	logic signed [W-1:0] y_s1;
	logic signed [31:0]  z_s1;

	prc_pkg::side_t      side_d;
	logic signed [16:0]  xv;
	logic signed [16:0]  yv;
	logic signed [31:0]  zv;
	logic signed [16:0]  re17;
	logic signed [16:0]  im17;
	logic signed [16:0]  m17;
	logic        [15:0]  ang_q1;
	logic        [15:0]  ang_fold;
	logic                hold;

	// to the datapath format, floor on a right shift
	function automatic logic signed [W-1:0] to_internal(input logic signed [16:0] v);
		logic signed [W+16:0] wide;
		wide = signed'({{W{v[16]}}, v});
		wide = (wide <<< LSH) >>> RSH;
		return wide[W-1:0];
	endfunction

	assign hold     = valid_s1 && next_hold;
	assign in_stall = hold;

	always_comb begin
		re17     = signed'({real_in[15], real_in});
		im17     = signed'({imag_in[15], imag_in});
		m17      = signed'({1'b0, magnitude_in});
		ang_q1   = angle_in + prc_pkg::ANG_QUARTER;
		ang_fold = angle_in ^ {ang_q1[15], 15'b0};
		side_d   = '0;
		side_d.action = action;
		xv = '0;
		yv = '0;
		zv = '0;
		if (action == prc_pkg::ACT_TO_POLAR) begin
			if (imag_in == 16'sd0) begin
				side_d.bypass  = 1'b1;
				side_d.byp_mag = real_in[15] ? 16'(-re17) : 16'(re17);
				side_d.byp_ang = real_in[15] ? prc_pkg::ANG_HALF : prc_pkg::ANG_ZERO;
			end else if (real_in == 16'sd0) begin
				side_d.bypass  = 1'b1;
				side_d.byp_mag = imag_in[15] ? 16'(-im17) : 16'(im17);
				side_d.byp_ang = imag_in[15] ? prc_pkg::ANG_THREE_Q : prc_pkg::ANG_QUARTER;
			end else begin
				// left half plane: fold onto the right, pi goes back on at the end
				side_d.half = real_in[15];
				xv = real_in[15] ? -re17 : re17;
				yv = real_in[15] ? -im17 : im17;
			end
		end else begin
			unique case (angle_in)
				prc_pkg::ANG_ZERO: begin
					side_d.bypass   = 1'b1;
					side_d.byp_real = magnitude_in[15] ? prc_pkg::SAT_POS : magnitude_in;
				end
				prc_pkg::ANG_QUARTER: begin
					side_d.bypass   = 1'b1;
					side_d.byp_imag = magnitude_in[15] ? prc_pkg::SAT_POS : magnitude_in;
				end
				prc_pkg::ANG_HALF: begin
					side_d.bypass   = 1'b1;
					side_d.byp_real = (magnitude_in > prc_pkg::SAT_NEG) ? prc_pkg::SAT_NEG
						: 16'(-m17);
				end
				prc_pkg::ANG_THREE_Q: begin
					side_d.bypass   = 1'b1;
					side_d.byp_imag = (magnitude_in > prc_pkg::SAT_NEG) ? prc_pkg::SAT_NEG
						: 16'(-m17);
				end
				default: begin
					// angles in the back half turn rotate by pi less, outputs negated
					side_d.half = ang_q1[15];
					xv = m17;
					zv = signed'({ang_fold, 16'b0});
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && in_valid) begin
			side_s1 <= side_d;
			x_s1    <= to_internal(xv);
			y_s1    <= to_internal(yv);
			z_s1    <= zv;
		end
	end

	assign ctl_out.valid = valid_s1;
	assign ctl_out.side  = side_s1;
	assign x_out         = x_s1;
	assign y_out         = y_s1;
	assign z_out         = z_s1;

endmodule

FILE: rtl/core/prc_cell.sv
// one cordic micro-rotation cell of the chain, vectoring or rotation by transaction
// depends on prc_pkg

module prc_cell #(
	parameter int DATA_WIDTH = 16,
	parameter int IDX        = 0
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  prc_pkg::ctl_t                                    ctl_in,
	input  logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] x_in,
	input  logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] y_in,
	input  logic signed [31:0]                               z_in,
	input  logic                                             next_hold,
	output logic                                             hold,
	output prc_pkg::ctl_t                                    ctl_out,
	output logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] x_out,
	output logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] y_out,
	output logic signed [31:0]                               z_out
);

	localparam int W = DATA_WIDTH + prc_pkg::GUARD_BITS;
	localparam logic signed [31:0] ATAN = signed'(prc_pkg::ATAN_TURNS[IDX]);

	logic                valid_q;
	prc_pkg::side_t      side_q;
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [31:0]  z_q;

	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic signed [W-1:0] x_nx;
	logic signed [W-1:0] y_nx;
	logic signed [31:0]  z_nx;
	logic                pos;

	assign hold = valid_q && next_hold;

	always_comb begin
		xs = x_in >>> IDX;
		ys = y_in >>> IDX;
		// vectoring steers by the sign of y, rotation by the sign of the residual angle
		pos = (ctl_in.side.action == prc_pkg::ACT_TO_POLAR) ? y_in[W-1] : !z_in[31];
		if (pos) begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - ATAN;
		end else begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && ctl_in.valid) begin
			side_q <= ctl_in.side;
			x_q    <= x_nx;
			y_q    <= y_nx;
			z_q    <= z_nx;
		end
	end

	assign ctl_out.valid = valid_q;
	assign ctl_out.side  = side_q;
	assign x_out         = x_q;
	assign y_out         = y_q;
	assign z_out         = z_q;

endmodule

FILE: rtl/core/prc_post.sv
// output stages: gain removal in split partial products, rounding, saturation, angle
// depends on prc_pkg

module prc_post #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  prc_pkg::ctl_t                                    ctl_in,
	input  logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] x_in,
	input  logic signed [DATA_WIDTH+prc_pkg::GUARD_BITS-1:0] y_in,
	input  logic signed [31:0]                               z_in,
	output logic                                             hold,
	output logic                                             out_valid,
	input  logic                                             out_stall,
	output logic signed [15:0]                               real_out,
	output logic signed [15:0]                               imag_out,
	output logic        [15:0]                               magnitude_out,
	output logic        [15:0]                               angle_out
);

	localparam int W    = DATA_WIDTH + prc_pkg::GUARD_BITS;
	localparam int LO_W = (W + 1) / 2;
	localparam int HI_W = W - LO_W;
	localparam int S    = DATA_WIDTH + 17;
	localparam int SW   = W + 33;
	localparam int G_W  = SW - S;
	localparam logic [SW-1:0] RND = SW'(1) << (S - 1);

	logic                 valid_s1;
	prc_pkg::side_t       side_s1;
	logic [LO_W+31:0]     plx_s1;
	logic [HI_W+31:0]     phx_s1;
	logic [LO_W+31:0]     ply_s1;
	logic [HI_W+31:0]     phy_s1;
	logic                 sx_s1;
	logic                 sy_s1;
	logic [15:0]          ang_s1;

	logic                 valid_s2;
	logic [15:0]          real_s2;
	logic [15:0]          imag_s2;
	logic [15:0]          mag_s2;
	logic [15:0]          ang_s2;

	logic [W-1:0]         ax;
	logic [W-1:0]         ay;
	logic [31:0]          a32;
	logic [31:0]          a32_rnd;
	logic [G_W-1:0]       gx;
	logic [G_W-1:0]       gy;
	logic [15:0]          real_d;
	logic [15:0]          imag_d;
	logic [15:0]          mag_d;
	logic [15:0]          ang_d;
	logic                 hold_s1;
	logic                 hold_s2;

	function automatic logic [G_W-1:0] gain_round(input logic [HI_W+31:0] ph,
			input logic [LO_W+31:0] pl);
		logic [SW-1:0] sum;
		sum = (SW'(ph) << LO_W) + SW'(pl) + RND;
		return sum[SW-1:S];
	endfunction

	function automatic logic [15:0] sat_signed(input logic [G_W-1:0] g, input logic neg);
		logic [15:0] r;
		if (neg) begin
			r = (g > G_W'(prc_pkg::SAT_NEG)) ? prc_pkg::SAT_NEG : 16'(-g[15:0]);
		end else begin
			r = (g > G_W'(prc_pkg::SAT_POS)) ? prc_pkg::SAT_POS : g[15:0];
		end
		return r;
	endfunction

	assign hold_s2 = valid_s2 && out_stall;
	assign hold_s1 = valid_s1 && hold_s2;
	assign hold    = hold_s1;

	always_comb begin
		ax = x_in[W-1] ? W'(-x_in) : W'(x_in);
		ay = y_in[W-1] ? W'(-y_in) : W'(y_in);
		// pi goes back on for a folded left-half-plane vector
		a32 = z_in + {ctl_in.side.half && (ctl_in.side.action == prc_pkg::ACT_TO_POLAR),
			31'b0};
		a32_rnd = a32 + prc_pkg::ANG_ROUND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold_s1) begin
			valid_s1 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1 && ctl_in.valid) begin
			side_s1 <= ctl_in.side;
			plx_s1  <= (LO_W+32)'(ax[LO_W-1:0]) * (LO_W+32)'(prc_pkg::INV_GAIN);
			phx_s1  <= (HI_W+32)'(ax[W-1:LO_W]) * (HI_W+32)'(prc_pkg::INV_GAIN);
			ply_s1  <= (LO_W+32)'(ay[LO_W-1:0]) * (LO_W+32)'(prc_pkg::INV_GAIN);
			phy_s1  <= (HI_W+32)'(ay[W-1:LO_W]) * (HI_W+32)'(prc_pkg::INV_GAIN);
			sx_s1   <= x_in[W-1];
			sy_s1   <= y_in[W-1];
			ang_s1  <= a32_rnd[31:16];
		end
	end

	always_comb begin
		gx     = gain_round(phx_s1, plx_s1);
		gy     = gain_round(phy_s1, ply_s1);
		real_d = '0;
		imag_d = '0;
		mag_d  = '0;
		ang_d  = '0;
		if (side_s1.bypass) begin
			real_d = side_s1.byp_real;
			imag_d = side_s1.byp_imag;
			mag_d  = side_s1.byp_mag;
			ang_d  = side_s1.byp_ang;
		end else if (side_s1.action == prc_pkg::ACT_TO_POLAR) begin
			if (!sx_s1) begin
				mag_d = (gx > G_W'(prc_pkg::MAG_MAX)) ? prc_pkg::MAG_MAX : gx[15:0];
			end
			ang_d = ang_s1;
		end else begin
			real_d = sat_signed(gx, sx_s1 ^ side_s1.half);
			imag_d = sat_signed(gy, sy_s1 ^ side_s1.half);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hold_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s2 && valid_s1) begin
			real_s2 <= real_d;
			imag_s2 <= imag_d;
			mag_s2  <= mag_d;
			ang_s2  <= ang_d;
		end
	end

	assign out_valid     = valid_s2;
	assign real_out      = signed'(real_s2);
	assign imag_out      = signed'(imag_s2);
	assign magnitude_out = mag_s2;
	assign angle_out     = ang_s2;

endmodule
